[rtl/tff_pkg.sv]
// Shared types for the triangle tangent frame block.
// Job record passed from the corner front end to the math back end,
// back end sequencer states and corner phase type.
package tff_pkg;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [15:0]      idx_a;
        logic [15:0]      idx_b;
        logic [15:0]      idx_c;
        logic [5:0][32:0] e;      // edge deltas e1.xyz, e2.xyz
        logic [3:0][32:0] d;      // uv deltas d1.u d1.v d2.u d2.v
        logic             last;
    } t_job;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_THIRD
    } t_phase;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DET,
        S_DSGN,
        S_PROD,
        S_DIFF,
        S_NORM,
        S_SQ,
        S_SQRT,
        S_DIVI,
        S_DIV,
        S_DONE
    } t_back_state;

endpackage

[rtl/triangle_tangent_frame.sv]
// Per-face tangent frame from triangle corners with texture coordinates.
// Input channel i_valid/o_ready carries one corner per transfer: index,
// Q15.16 position and uv, and a mesh end flag. Output channel
// o_valid/i_ready carries one result per complete triangle: three indices,
// Q1.14 unit tangent and binormal, degenerate and last-triangle flags.
// The first two corners of a triangle are always accepted. The
// closing corner is taken as soon as the job queue has room.
// The back end works on one triangle at a time and skips the math on a zero uv
// determinant. It uses two 32x32 multipliers shared over the products and
// squares, a 32-step square root per vector and a 15-step divide.
// While it works, the queue takes the jobs of later triangles.
// A finished result waits in the output register while the back end
// starts the next job; with the receiver stalled, the queue fills and
// then o_ready drops on the next closing corner.
// Synchronous active-low reset empties the queue, drops any partial
// triangle and clears o_valid.
// Depends on tff_pkg, tff_front, tff_queue and tff_back.
module triangle_tangent_frame #(
    parameter int QUEUE_DEPTH = tff_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [15:0]        i_vertex_index,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_tex_u,
    input  logic signed [31:0] i_tex_v,
    input  logic               i_mesh_end,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [15:0]        o_corner_a,
    output logic [15:0]        o_corner_b,
    output logic [15:0]        o_corner_c,
    output logic signed [15:0] o_tangent_x,
    output logic signed [15:0] o_tangent_y,
    output logic signed [15:0] o_tangent_z,
    output logic signed [15:0] o_binormal_x,
    output logic signed [15:0] o_binormal_y,
    output logic signed [15:0] o_binormal_z,
    output logic               o_degenerate,
    output logic               o_last_triangle
);
    import tff_pkg::*;

    logic w_push_valid, w_push_ready;
    logic w_pop_valid, w_pop_ready;
    t_job w_push_job, w_pop_job;

    tff_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_vertex_index (i_vertex_index),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_tex_u        (i_tex_u),
        .i_tex_v        (i_tex_v),
        .i_mesh_end     (i_mesh_end),
        .o_push_valid   (w_push_valid),
        .o_push_job     (w_push_job),
        .i_push_ready   (w_push_ready)
    );

    tff_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_job   (w_push_job),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_job    (w_pop_job)
    );

    tff_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (w_pop_valid),
        .o_job_ready     (w_pop_ready),
        .i_job           (w_pop_job),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_corner_a      (o_corner_a),
        .o_corner_b      (o_corner_b),
        .o_corner_c      (o_corner_c),
        .o_tangent_x     (o_tangent_x),
        .o_tangent_y     (o_tangent_y),
        .o_tangent_z     (o_tangent_z),
        .o_binormal_x    (o_binormal_x),
        .o_binormal_y    (o_binormal_y),
        .o_binormal_z    (o_binormal_z),
        .o_degenerate    (o_degenerate),
        .o_last_triangle (o_last_triangle)
    );

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push_valid |-> w_push_ready)
        else $error("closing corner pushed into a full queue");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> !w_push_ready)
        else $error("input stalled while the queue has room");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

[rtl/tff_front.sv]
// Corner front end: holds the first two corners of a triangle and, on the
// third, pushes the index triple and edge/uv deltas as a job.
// Depends on tff_pkg.
module tff_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [15:0]        i_vertex_index,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_tex_u,
    input  logic signed [31:0] i_tex_v,
    input  logic               i_mesh_end,
    output logic               o_push_valid,
    output tff_pkg::t_job      o_push_job,
    input  logic               i_push_ready
);
    import tff_pkg::*;

    t_phase      r_phase, n_phase;
    logic [15:0] r_idx [2];
    logic [31:0] r_pos [6];
    logic [31:0] r_tex [4];
    logic        w_accept;
    logic [31:0] w_p [3];
    logic [31:0] w_t [2];

    assign o_ready  = (r_phase != PH_THIRD) || i_push_ready;
    assign w_accept = i_valid && o_ready;
    assign w_p[0] = i_pos_x;
    assign w_p[1] = i_pos_y;
    assign w_p[2] = i_pos_z;
    assign w_t[0] = i_tex_u;
    assign w_t[1] = i_tex_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_phase = r_phase;
        if (w_accept) begin
            unique case (r_phase)
                PH_SECOND: n_phase = i_mesh_end ? PH_FIRST : PH_THIRD;
                PH_THIRD:  n_phase = PH_FIRST;
                default:   n_phase = i_mesh_end ? PH_FIRST : PH_SECOND;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && r_phase == PH_SECOND) begin
            r_idx[1] <= i_vertex_index;
            for (int i = 0; i < 3; i++) r_pos[3+i] <= w_p[i];
            for (int i = 0; i < 2; i++) r_tex[2+i] <= w_t[i];
        end else if (w_accept && r_phase != PH_THIRD) begin
            r_idx[0] <= i_vertex_index;
            for (int i = 0; i < 3; i++) r_pos[i] <= w_p[i];
            for (int i = 0; i < 2; i++) r_tex[i] <= w_t[i];
        end
    end

    assign o_push_valid = w_accept && (r_phase == PH_THIRD);

    always_comb begin
        o_push_job.idx_a = r_idx[0];
        o_push_job.idx_b = r_idx[1];
        o_push_job.idx_c = i_vertex_index;
        o_push_job.last  = i_mesh_end;
        for (int i = 0; i < 3; i++) begin
            o_push_job.e[i]   = {r_pos[3+i][31], r_pos[3+i]} - {r_pos[i][31], r_pos[i]};
            o_push_job.e[3+i] = {w_p[i][31], w_p[i]} - {r_pos[i][31], r_pos[i]};
        end
        for (int i = 0; i < 2; i++) begin
            o_push_job.d[i]   = {r_tex[2+i][31], r_tex[2+i]} - {r_tex[i][31], r_tex[i]};
            o_push_job.d[2+i] = {w_t[i][31], w_t[i]} - {r_tex[i][31], r_tex[i]};
        end
    end

endmodule

[rtl/tff_queue.sv]
// Short job queue between the front end and the back end.
// Depends on tff_pkg for the job record.
module tff_queue #(
    parameter int DEPTH = tff_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  tff_pkg::t_job i_push_job,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output tff_pkg::t_job o_pop_job
);
    import tff_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          w_push, w_pop;

    assign o_push_ready = (r_cnt != CW'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_job    = r_mem[r_rd];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        if (w_pop)  n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        if (w_push && !w_pop) n_cnt = r_cnt + 1'b1;
        else if (w_pop && !w_push) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_push_job;
    end

endmodule

[rtl/tff_back.sv]
// Math back end: block fit, uv determinant sign, tangent/binormal products,
// normalization with iterative square root and divide; registered result.
// Depends on tff_pkg.
module tff_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    output logic               o_job_ready,
    input  tff_pkg::t_job      i_job,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [15:0]        o_corner_a,
    output logic [15:0]        o_corner_b,
    output logic [15:0]        o_corner_c,
    output logic signed [15:0] o_tangent_x,
    output logic signed [15:0] o_tangent_y,
    output logic signed [15:0] o_tangent_z,
    output logic signed [15:0] o_binormal_x,
    output logic signed [15:0] o_binormal_y,
    output logic signed [15:0] o_binormal_z,
    output logic               o_degenerate,
    output logic               o_last_triangle
);
    import tff_pkg::*;

    t_back_state        r_state, n_state;
    logic [4:0]         r_cnt, n_cnt;
    logic               w_load;

    logic signed [31:0] r_e [6];
    logic signed [31:0] r_d [4];
    logic signed [63:0] r_p0, r_p1;
    logic               r_det_neg, r_det_zero;
    logic [62:0]        r_m [6];
    logic               r_sg [6];
    logic [62:0]        r_mx [2];
    logic [63:0]        r_x [2];
    logic [63:0]        r_r [2];
    logic [31:0]        r_len [2];
    logic [45:0]        r_rem [6];
    logic [14:0]        r_q [6];
    logic [15:0]        r_idx [3];
    logic               r_last;

    logic               r_out_valid;
    logic [15:0]        r_o_idx [3];
    logic [15:0]        r_o_vec [6];
    logic               r_o_degen, r_o_last;

    // block fit
    logic [32:0]        w_emag [6];
    logic [32:0]        w_dmag [4];
    logic [31:0]        w_efm [6];
    logic [31:0]        w_dfm [4];
    logic [31:0]        w_efit [6];
    logic [31:0]        w_dfit [4];
    logic               w_ek, w_dk;

    // multipliers
    logic signed [31:0] w_a0, w_b0, w_a1, w_b1;
    logic signed [63:0] w_p0, w_p1;
    logic [1:0]         w_lo, w_sqi;
    logic [2:0]         w_hi3, w_sqb;

    logic signed [63:0] w_det, w_diff, w_sv;
    logic [63:0]        w_smag;
    logic [5:0]         w_sh;
    logic               w_rt [2];
    logic               w_lt [2];
    logic [63:0]        w_bit;
    logic [63:0]        w_t [2];
    logic               w_ge [2];
    logic [45:0]        w_den [2];
    logic               w_vz [2];
    logic [15:0]        w_vec [6];

    always_comb begin
        w_ek = 1'b0;
        w_dk = 1'b0;
        for (int i = 0; i < 6; i++) begin
            w_emag[i] = i_job.e[i][32] ? (33'd0 - i_job.e[i]) : i_job.e[i];
            w_ek = w_ek | w_emag[i][32] | w_emag[i][31];
        end
        for (int i = 0; i < 4; i++) begin
            w_dmag[i] = i_job.d[i][32] ? (33'd0 - i_job.d[i]) : i_job.d[i];
            w_dk = w_dk | w_dmag[i][32] | w_dmag[i][31];
        end
        for (int i = 0; i < 6; i++) begin
            w_efm[i]  = w_ek ? w_emag[i][32:1] : w_emag[i][31:0];
            w_efit[i] = i_job.e[i][32] ? (32'd0 - w_efm[i]) : w_efm[i];
        end
        for (int i = 0; i < 4; i++) begin
            w_dfm[i]  = w_dk ? w_dmag[i][32:1] : w_dmag[i][31:0];
            w_dfit[i] = i_job.d[i][32] ? (32'd0 - w_dfm[i]) : w_dfm[i];
        end
    end

    assign w_lo  = (r_cnt < 5'd3) ? r_cnt[1:0] : 2'(r_cnt - 5'd3);
    assign w_hi3 = {1'b0, w_lo} + 3'd3;
    assign w_sqi = (r_cnt[1:0] == 2'd3) ? 2'd0 : r_cnt[1:0];
    assign w_sqb = {1'b0, w_sqi} + 3'd3;

    always_comb begin
        w_a0 = '0;
        w_b0 = '0;
        w_a1 = '0;
        w_b1 = '0;
        unique case (r_state)
            S_DET: begin
                w_a0 = r_d[0]; w_b0 = r_d[3];
                w_a1 = r_d[2]; w_b1 = r_d[1];
            end
            S_PROD: begin
                if (r_cnt < 5'd3) begin
                    w_a0 = r_d[3]; w_b0 = r_e[{1'b0, w_lo}];
                    w_a1 = r_d[1]; w_b1 = r_e[w_hi3];
                end else begin
                    w_a0 = r_d[0]; w_b0 = r_e[w_hi3];
                    w_a1 = r_d[2]; w_b1 = r_e[{1'b0, w_lo}];
                end
            end
            S_SQ: begin
                w_a0 = {1'b0, r_m[{1'b0, w_sqi}][30:0]};
                w_b0 = {1'b0, r_m[{1'b0, w_sqi}][30:0]};
                w_a1 = {1'b0, r_m[w_sqb][30:0]};
                w_b1 = {1'b0, r_m[w_sqb][30:0]};
            end
            default: ;
        endcase
    end

    assign w_p0   = w_a0 * w_b0;
    assign w_p1   = w_a1 * w_b1;
    assign w_det  = r_p0 - r_p1;
    assign w_diff = r_p0 - r_p1;
    assign w_sv   = r_det_neg ? (64'sd0 - w_diff) : w_diff;
    assign w_smag = w_sv[63] ? (64'd0 - w_sv) : w_sv;
    assign w_sh   = 6'(6'd32 >> r_cnt[2:0]);
    assign w_bit  = 64'h4000_0000_0000_0000 >> {r_cnt, 1'b0};

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_rt[l]  = ((r_mx[l] >> w_sh) >> 30) != 63'd0;
            w_lt[l]  = (w_sh <= 6'd16) && ((r_mx[l] >> (6'd31 - w_sh)) == 63'd0);
            w_t[l]   = r_r[l] + w_bit;
            w_ge[l]  = r_x[l] >= w_t[l];
            w_den[l] = {r_len[l], 14'd0} >> r_cnt[3:0];
            w_vz[l]  = (r_mx[l] == 63'd0);
        end
        for (int c = 0; c < 6; c++) begin
            if (r_det_zero || w_vz[c/3]) w_vec[c] = 16'd0;
            else if (r_sg[c]) w_vec[c] = 16'd0 - {1'b0, r_q[c]};
            else w_vec[c] = {1'b0, r_q[c]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_job_ready = 1'b0;
        w_load      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_job_ready = 1'b1;
                if (i_job_valid) n_state = S_DET;
            end
            S_DET:  n_state = S_DSGN;
            S_DSGN: begin
                n_cnt   = '0;
                n_state = (w_det == 64'sd0) ? S_DONE : S_PROD;
            end
            S_PROD: n_state = S_DIFF;
            S_DIFF: begin
                if (r_cnt == 5'd5) begin
                    n_cnt   = '0;
                    n_state = S_NORM;
                end else begin
                    n_cnt   = r_cnt + 5'd1;
                    n_state = S_PROD;
                end
            end
            S_NORM: begin
                if (r_cnt == 5'd5) begin
                    n_cnt   = '0;
                    n_state = S_SQ;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_SQ: begin
                if (r_cnt == 5'd3) begin
                    n_cnt   = '0;
                    n_state = S_SQRT;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_SQRT: begin
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) n_state = S_DIVI;
            end
            S_DIVI: begin
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_cnt == 5'd14) begin
                    n_cnt   = '0;
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    for (int i = 0; i < 6; i++) r_e[i] <= w_efit[i];
                    for (int i = 0; i < 4; i++) r_d[i] <= w_dfit[i];
                    r_idx[0]   <= i_job.idx_a;
                    r_idx[1]   <= i_job.idx_b;
                    r_idx[2]   <= i_job.idx_c;
                    r_last     <= i_job.last;
                    r_mx[0]    <= '0;
                    r_mx[1]    <= '0;
                end
            end
            S_DET, S_PROD: begin
                r_p0 <= w_p0;
                r_p1 <= w_p1;
            end
            S_DSGN: begin
                r_det_neg  <= w_det[63];
                r_det_zero <= (w_det == 64'sd0);
            end
            S_DIFF: begin
                r_m[r_cnt[2:0]]  <= w_smag[62:0];
                r_sg[r_cnt[2:0]] <= w_sv[63];
                if (w_smag[62:0] > r_mx[r_cnt >= 5'd3]) r_mx[r_cnt >= 5'd3] <= w_smag[62:0];
            end
            S_NORM: begin
                for (int l = 0; l < 2; l++) begin
                    r_x[l] <= '0;
                    r_r[l] <= '0;
                    if (w_rt[l]) begin
                        r_mx[l] <= r_mx[l] >> w_sh;
                        for (int i = 0; i < 3; i++) r_m[3*l+i] <= r_m[3*l+i] >> w_sh;
                    end else if (w_lt[l]) begin
                        r_mx[l] <= r_mx[l] << w_sh;
                        for (int i = 0; i < 3; i++) r_m[3*l+i] <= r_m[3*l+i] << w_sh;
                    end
                end
            end
            S_SQ: begin
                if (r_cnt != 5'd3) begin
                    r_p0 <= w_p0;
                    r_p1 <= w_p1;
                end
                if (r_cnt != 5'd0) begin
                    r_x[0] <= r_x[0] + r_p0;
                    r_x[1] <= r_x[1] + r_p1;
                end
            end
            S_SQRT: begin
                for (int l = 0; l < 2; l++) begin
                    if (w_ge[l]) begin
                        r_x[l] <= r_x[l] - w_t[l];
                        r_r[l] <= (r_r[l] >> 1) + w_bit;
                    end else begin
                        r_r[l] <= r_r[l] >> 1;
                    end
                end
            end
            S_DIVI: begin
                for (int l = 0; l < 2; l++) begin
                    r_len[l] <= r_r[l][31:0];
                    for (int i = 0; i < 3; i++) begin
                        r_rem[3*l+i] <= {r_m[3*l+i][30:0], 14'd0} + 46'(r_r[l][31:1]);
                        r_q[3*l+i]   <= '0;
                    end
                end
            end
            S_DIV: begin
                for (int l = 0; l < 2; l++) begin
                    for (int i = 0; i < 3; i++) begin
                        if (r_rem[3*l+i] >= w_den[l]) begin
                            r_rem[3*l+i] <= r_rem[3*l+i] - w_den[l];
                            r_q[3*l+i]   <= {r_q[3*l+i][13:0], 1'b1};
                        end else begin
                            r_q[3*l+i]   <= {r_q[3*l+i][13:0], 1'b0};
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            for (int i = 0; i < 3; i++) r_o_idx[i] <= r_idx[i];
            for (int c = 0; c < 6; c++) r_o_vec[c] <= w_vec[c];
            r_o_degen <= r_det_zero || w_vz[0] || w_vz[1];
            r_o_last  <= r_last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_corner_a      = r_o_idx[0];
    assign o_corner_b      = r_o_idx[1];
    assign o_corner_c      = r_o_idx[2];
    assign o_tangent_x     = r_o_vec[0];
    assign o_tangent_y     = r_o_vec[1];
    assign o_tangent_z     = r_o_vec[2];
    assign o_binormal_x    = r_o_vec[3];
    assign o_binormal_y    = r_o_vec[4];
    assign o_binormal_z    = r_o_vec[5];
    assign o_degenerate    = r_o_degen;
    assign o_last_triangle = r_o_last;

endmodule

[tb/tb_triangle_tangent_frame.sv]
// Testbench for triangle_tangent_frame: directed corner table, then random triangles.
// Results are predicted by an internal fixed-point tangent frame model and checked in order.
// Depends on rtl/tff_pkg.sv and rtl/triangle_tangent_frame.sv.
`timescale 1ns / 100ps

module tb_triangle_tangent_frame;

    typedef struct {
        logic [15:0]        idx;
        logic signed [31:0] px, py, pz, tu, tv;
        logic               mend;
    } t_corner;

    typedef struct {
        logic [15:0]        ca, cb, cc;
        logic signed [15:0] tx, ty, tz, bx, by, bz;
        logic               degen, last;
    } t_frame;

    typedef struct {
        t_corner c;
        logic    has_exp;
        t_frame  f;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [15:0]        i_vertex_index;
    logic signed [31:0] i_pos_x, i_pos_y, i_pos_z, i_tex_u, i_tex_v;
    logic               i_mesh_end;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [15:0]        o_corner_a, o_corner_b, o_corner_c;
    logic signed [15:0] o_tangent_x, o_tangent_y, o_tangent_z;
    logic signed [15:0] o_binormal_x, o_binormal_y, o_binormal_z;
    logic               o_degenerate, o_last_triangle;

    triangle_tangent_frame DUT (.*);

    tff_pkg::t_phase    phase;
    t_corner            held[2];
    t_frame             frame_q[$];
    int                 fails;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    logic               recv_hold;
    longint             cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint mag64(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic void fit_group(ref longint v[6], input int n);
        longint mx;
        int     k;
        mx = 0;
        k = 0;
        for (int i = 0; i < n; i++) if (mag64(v[i]) > mx) mx = mag64(v[i]);
        while ((mx >>> k) >= 64'sh8000_0000) k++;
        for (int i = 0; i < n; i++)
            v[i] = v[i] < 0 ? -(mag64(v[i]) >>> k) : (mag64(v[i]) >>> k);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Q1.14 unit vector; returns 0 for a zero vector.
    function automatic bit unit_vec(longint c[3], output logic signed [15:0] o[3]);
        logic [63:0] m[3];
        logic [63:0] mx, sq, len, q;
        mx = 0;
        sq = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = mag64(c[i]);
            if (m[i] > mx) mx = m[i];
            o[i] = 0;
        end
        if (mx == 0) return 0;
        while (mx >= 64'h8000_0000) begin
            mx >>= 1;
            for (int i = 0; i < 3; i++) m[i] >>= 1;
        end
        while (mx < 64'h4000_0000) begin
            mx <<= 1;
            for (int i = 0; i < 3; i++) m[i] <<= 1;
        end
        for (int i = 0; i < 3; i++) sq += m[i] * m[i];
        len = int_sqrt(sq);
        for (int i = 0; i < 3; i++) begin
            q = (m[i] * 16384 + len / 2) / len;
            o[i] = c[i] < 0 ? -q[15:0] : q[15:0];
        end
        return 1;
    endfunction

    function automatic t_frame face_frame(t_corner a, t_corner b, t_corner c);
        t_frame             f;
        longint             e[6], d[6], det, tv[3], bv[3];
        logic signed [15:0] tu[3], bu[3];
        e = '{longint'(b.px) - longint'(a.px), longint'(b.py) - longint'(a.py),
              longint'(b.pz) - longint'(a.pz), longint'(c.px) - longint'(a.px),
              longint'(c.py) - longint'(a.py), longint'(c.pz) - longint'(a.pz)};
        d = '{longint'(b.tu) - longint'(a.tu), longint'(b.tv) - longint'(a.tv),
              longint'(c.tu) - longint'(a.tu), longint'(c.tv) - longint'(a.tv), 0, 0};
        fit_group(e, 6);
        fit_group(d, 4);
        f.degen = 0;
        tu = '{0, 0, 0};
        bu = '{0, 0, 0};
        det = d[0] * d[3] - d[2] * d[1];
        if (det == 0) begin
            f.degen = 1;
        end else begin
            for (int i = 0; i < 3; i++) begin
                tv[i] = d[3] * e[i] - d[1] * e[3 + i];
                bv[i] = d[0] * e[3 + i] - d[2] * e[i];
                if (det < 0) begin
                    tv[i] = -tv[i];
                    bv[i] = -bv[i];
                end
            end
            if (!unit_vec(tv, tu)) f.degen = 1;
            if (!unit_vec(bv, bu)) f.degen = 1;
        end
        f.ca = a.idx;
        f.cb = b.idx;
        f.cc = c.idx;
        {f.tx, f.ty, f.tz} = {tu[0], tu[1], tu[2]};
        {f.bx, f.by, f.bz} = {bu[0], bu[1], bu[2]};
        f.last = c.mend;
        return f;
    endfunction

    // Advances the corner state; returns 1 with a frame on a closing corner.
    function automatic bit take_corner(t_corner c, output t_frame f);
        case (phase)
            tff_pkg::PH_SECOND: begin
                held[1] = c;
                phase = c.mend ? tff_pkg::PH_FIRST : tff_pkg::PH_THIRD;
                return 0;
            end
            tff_pkg::PH_THIRD: begin
                phase = tff_pkg::PH_FIRST;
                f = face_frame(held[0], held[1], c);
                return 1;
            end
            default: begin
                held[0] = c;
                phase = c.mend ? tff_pkg::PH_FIRST : tff_pkg::PH_SECOND;
                return 0;
            end
        endcase
    endfunction

    function automatic t_corner mk(int idx, int px, int py, int pz, int u, int v, bit me);
        t_corner c;
        c.idx = 16'(idx);
        c.px = px;
        c.py = py;
        c.pz = pz;
        c.tu = u;
        c.tv = v;
        c.mend = me;
        return c;
    endfunction

    function automatic int rnd32();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
            default: return int'($urandom_range(0, 2 << 16)) - (1 << 16);
        endcase
    endfunction

    function automatic t_corner rnd_corner(bit me);
        return mk($urandom(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), me);
    endfunction

    task automatic send(t_corner c);
        i_vertex_index <= c.idx;
        i_pos_x <= c.px;
        i_pos_y <= c.py;
        i_pos_z <= c.pz;
        i_tex_u <= c.tu;
        i_tex_v <= c.tv;
        i_mesh_end <= c.mend;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic send_checked(t_corner c);
        t_frame f;
        if (take_corner(c, f)) frame_q.push_back(f);
        send(c);
    endtask

    task automatic chk(string n, longint e, longint a);
        if (e != a) begin
            $error("%s expected %0d actual %0d", n, e, a);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_frame f;
        if (i_rst_n && o_valid && i_ready) begin
            if (frame_q.size() == 0) begin
                $error("unexpected result transfer");
                fails++;
            end else begin
                f = frame_q.pop_front();
                chk("corner_a", f.ca, o_corner_a);
                chk("corner_b", f.cb, o_corner_b);
                chk("corner_c", f.cc, o_corner_c);
                chk("tangent_x", f.tx, o_tangent_x);
                chk("tangent_y", f.ty, o_tangent_y);
                chk("tangent_z", f.tz, o_tangent_z);
                chk("binormal_x", f.bx, o_binormal_x);
                chk("binormal_y", f.by, o_binormal_y);
                chk("binormal_z", f.bz, o_binormal_z);
                chk("degenerate", f.degen, o_degenerate);
                chk("last_triangle", f.last, o_last_triangle);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (recv_hold) i_ready <= 1'b0;
        else i_ready <= $urandom_range(0, 99) >= recv_idle_pct;
        if (cycles > 2000000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_row   rows[$];
        t_row   r;
        t_frame f;
        int     n;
        bit     hold_done;
        phase = tff_pkg::PH_FIRST;
        fails = 0;
        hold_done = 0;
        send_idle_pct = 10;
        recv_idle_pct = 68;
        recv_hold = 0;
        i_rst_n = 0;
        i_valid = 0;
        {i_vertex_index, i_pos_x, i_pos_y, i_pos_z, i_tex_u, i_tex_v, i_mesh_end} = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero uv determinant: all zero frame, degenerate set
        r.has_exp = 1;
        r.f = '{0, 1, 2, 0, 0, 0, 0, 0, 0, 1, 0};
        r.c = mk(0, 0, 0, 0, 0, 0, 0);
        rows.push_back(r);
        r.c = mk(1, 1 << 16, 0, 0, 0, 0, 0);
        rows.push_back(r);
        r.c = mk(2, 0, 1 << 16, 0, 0, 0, 0);
        rows.push_back(r);
        r.has_exp = 0;
        // axis aligned triangle
        rows.push_back('{mk(16'hffff, 0, 0, 0, 0, 0, 0), 0, f});
        rows.push_back('{mk(3, 1 << 16, 0, 0, 1 << 16, 0, 0), 0, f});
        rows.push_back('{mk(4, 0, 1 << 16, 0, 0, 1 << 16, 0), 0, f});
        // extremes with negative determinant, mesh end closes it
        rows.push_back('{mk(5, 32'sh8000_0000, 32'sh7fff_ffff, 0,
                            32'sh7fff_ffff, 32'sh8000_0000, 0), 0, f});
        rows.push_back('{mk(6, 32'sh7fff_ffff, 32'sh8000_0000, -1,
                            32'sh8000_0000, 32'sh8000_0000, 0), 0, f});
        rows.push_back('{mk(7, -1, -1, 32'sh7fff_ffff,
                            32'sh8000_0000, 32'sh7fff_ffff, 1), 0, f});
        // early mesh end on first, then on second corner
        rows.push_back('{mk(8, 5, 5, 5, 5, 5, 1), 0, f});
        rows.push_back('{mk(9, 5, 5, 5, 5, 5, 0), 0, f});
        rows.push_back('{mk(10, 6, 6, 6, 6, 6, 1), 0, f});
        // collinear positions: zero length tangent and binormal
        rows.push_back('{mk(11, 0, 0, 0, 0, 0, 0), 0, f});
        rows.push_back('{mk(12, 0, 0, 0, 1 << 16, 0, 0), 0, f});
        rows.push_back('{mk(13, 0, 0, 0, 0, 1 << 16, 0), 0, f});

        foreach (rows[i]) begin
            if (take_corner(rows[i].c, f))
                frame_q.push_back(rows[i].has_exp ? rows[i].f : f);
            send(rows[i].c);
        end

        for (n = 0; n < 1200; ) begin
            if (n >= 400 && n < 800) begin
                send_idle_pct = 68;
                recv_idle_pct = 10;
            end
            if (n >= 800) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (n >= 1000 && !hold_done) begin
                hold_done = 1;
                fork
                    begin
                        recv_hold = 1;
                        repeat (600) @(posedge i_clk);
                        recv_hold = 0;
                    end
                join_none
            end
            if ($urandom_range(0, 9) == 0) begin
                send_checked(rnd_corner($urandom_range(0, 1)));
                n++;
            end else begin
                for (int k = 0; k < 3; k++) send_checked(rnd_corner(k == 2 && $urandom_range(0, 7) == 0));
                n += 3;
            end
        end
        i_valid <= 1'b0;
        while (frame_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fails == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

endmodule

[filelist.f]
rtl/tff_pkg.sv
rtl/tff_front.sv
rtl/tff_queue.sv
rtl/tff_back.sv
rtl/triangle_tangent_frame.sv
tb/tb_triangle_tangent_frame.sv
